@@ rtl/tspf_pkg.sv @@
`timescale 1ns / 1ps

package tspf_pkg;

   // Width of the C-style unsigned arithmetic that the pressure formula wraps in.
   localparam int WORD_BITS = 32;

   // Width of the plate resistance register and of the serial multiplier operand.
   localparam int PLATE_BITS = 16;

   // Width of the max pressure register.
   localparam int MAX_BITS = 16;

   // Default converter resolution.
   localparam int ADC_BITS_DEFAULT = 12;

   // Configuration port.
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type REG_PLATE = 2'd0;
   localparam csr_index_type REG_MAX   = 2'd1;
   localparam csr_index_type REG_PEN   = 2'd2;

   // Register reset values.
   localparam logic [PLATE_BITS-1:0] PLATE_RESET = '0;
   localparam logic [MAX_BITS-1:0]   MAX_RESET   = MAX_BITS'(4095);
   localparam logic                  PEN_RESET   = 1'b1;

endpackage

@@ rtl/touch_sample_pressure_filter.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  sample_x, sample_y, sample_z1, sample_z2, pen_down
// rsp      out        rsp_valid / rsp_ready  touching, pos_x, pos_y, pressure
// csr      in         APB write/read         plate_resistance_ohms, max_pressure, pen_signal_present
//
// An item with the pen signal in use and the pen lifted goes from loading straight to
// the decision step. Any other item is loaded, then runs the bit-serial multiply by X,
// the multiply by the plate resistance, the restoring division by Z1, a rounding step
// and the step that decides the report.
// Reset is synchronous and active high; it ends any touch session and restores the
// register defaults. A result waiting on rsp_ready does not stop the next item from being
// accepted; only the decision step of that next item waits for the output register.

module touch_sample_pressure_filter #(
   parameter int ADC_BITS = tspf_pkg::ADC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [ADC_BITS-1:0]                   req_sample_x,
   input  logic [ADC_BITS-1:0]                   req_sample_y,
   input  logic [ADC_BITS-1:0]                   req_sample_z1,
   input  logic [ADC_BITS-1:0]                   req_sample_z2,
   input  logic                                  req_pen_down,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_touching,
   output logic [ADC_BITS-1:0]                   rsp_pos_x,
   output logic [ADC_BITS-1:0]                   rsp_pos_y,
   output logic [tspf_pkg::WORD_BITS-ADC_BITS-1:0] rsp_pressure,

   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [tspf_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [tspf_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [tspf_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   import tspf_pkg::*;

   localparam int PRESS_BITS = WORD_BITS - ADC_BITS;
   localparam int CNT_BITS   = $clog2(WORD_BITS);

   // The rounding constant is half an LSB of the final shift, less one.
   localparam logic [WORD_BITS-1:0] ROUND_ADD = WORD_BITS'((1 << (ADC_BITS - 1)) - 1);
   // A reading of all ones means the converter saw no contact on X.
   localparam logic [ADC_BITS-1:0]  ADC_MAX   = {ADC_BITS{1'b1}};

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL_X = 3'd1;
   localparam logic [2:0] ST_MUL_R = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_ROUND = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   // Configuration registers.
   logic [PLATE_BITS-1:0] plate_ff;
   logic [MAX_BITS-1:0]   max_ff;
   logic                  pen_cfg_ff;

   // Control state.
   logic [2:0]            state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  session_ff, session_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Item working registers.
   logic [ADC_BITS-1:0]   x_ff, x_in;
   logic [ADC_BITS-1:0]   y_ff, y_in;
   logic [ADC_BITS-1:0]   z1_ff, z1_in;
   logic                  pen_up_ff, pen_up_in;
   logic                  force_zero_ff, force_zero_in;
   logic [WORD_BITS-1:0]  acc_ff, acc_in;
   logic [WORD_BITS-1:0]  mcand_ff, mcand_in;
   logic [PLATE_BITS-1:0] mplier_ff, mplier_in;
   logic [ADC_BITS:0]     rem_ff, rem_in;

   // Output register.
   logic                  touching_ff, touching_in;
   logic [ADC_BITS-1:0]   pos_x_ff, pos_x_in;
   logic [ADC_BITS-1:0]   pos_y_ff, pos_y_in;
   logic [PRESS_BITS-1:0] pressure_ff, pressure_in;

   logic                  req_fire;
   logic                  csr_write;
   csr_index_type         csr_index;
   logic [WORD_BITS-1:0]  acc_add;
   logic [ADC_BITS:0]     div_trial;
   logic                  div_fits;
   logic [PRESS_BITS-1:0] press_value;
   logic                  out_free;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_touching = touching_ff;
   assign rsp_pos_x    = pos_x_ff;
   assign rsp_pos_y    = pos_y_ff;
   assign rsp_pressure = pressure_ff;

   // Register read-back.
   always_comb begin
      unique case (csr_index)
         REG_PLATE: csr_prdata = CSR_DATA_BITS'(plate_ff);
         REG_MAX:   csr_prdata = CSR_DATA_BITS'(max_ff);
         REG_PEN:   csr_prdata = CSR_DATA_BITS'(pen_cfg_ff);
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plate_ff   <= PLATE_RESET;
         max_ff     <= MAX_RESET;
         pen_cfg_ff <= PEN_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_PLATE: plate_ff   <= csr_pwdata[PLATE_BITS-1:0];
            REG_MAX:   max_ff     <= csr_pwdata[MAX_BITS-1:0];
            REG_PEN:   pen_cfg_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Shared datapath pieces: the shift-add adder of both multiply passes and the trial
   // subtraction of the restoring divider, which shifts the dividend in one bit a cycle.
   assign acc_add     = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
   assign div_trial   = {rem_ff[ADC_BITS-1:0], acc_ff[WORD_BITS-1]};
   assign div_fits    = (div_trial >= {1'b0, z1_ff});
   // After rounding the quotient sits in the accumulator; the report keeps its top bits.
   assign press_value = force_zero_ff ? '0 : acc_ff[WORD_BITS-1:ADC_BITS];
   assign out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      session_in    = session_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      x_in          = x_ff;
      y_in          = y_ff;
      z1_in         = z1_ff;
      pen_up_in     = pen_up_ff;
      force_zero_in = force_zero_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      rem_in        = rem_ff;
      touching_in   = touching_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      pressure_in   = pressure_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               x_in          = (req_sample_x == ADC_MAX) ? '0 : req_sample_x;
               y_in          = req_sample_y;
               z1_in         = req_sample_z1;
               pen_up_in     = pen_cfg_ff && !req_pen_down;
               force_zero_in = (req_sample_x == ADC_MAX) || (req_sample_x == '0) ||
                               (req_sample_z1 == '0);
               acc_in        = '0;
               mcand_in      = WORD_BITS'(req_sample_z2) - WORD_BITS'(req_sample_z1);
               mplier_in     = PLATE_BITS'((req_sample_x == ADC_MAX) ? '0 : req_sample_x);
               cnt_in        = CNT_BITS'(ADC_BITS - 1);
               // A lifted pen needs no pressure, so that item goes straight to the report.
               state_in      = (pen_cfg_ff && !req_pen_down) ? ST_DONE : ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - 1'b1;
            acc_in    = acc_add;
            if (cnt_ff == '0) begin
               // Second pass multiplies the product so far by the plate resistance.
               mcand_in  = acc_add;
               acc_in    = '0;
               mplier_in = plate_ff;
               cnt_in    = CNT_BITS'(PLATE_BITS - 1);
               state_in  = ST_MUL_R;
            end
         end
         ST_MUL_R: begin
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - 1'b1;
            acc_in    = acc_add;
            if (cnt_ff == '0) begin
               rem_in   = '0;
               cnt_in   = CNT_BITS'(WORD_BITS - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = div_fits ? (div_trial - {1'b0, z1_ff}) : div_trial;
            acc_in = {acc_ff[WORD_BITS-2:0], div_fits};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            acc_in   = acc_ff + ROUND_ADD;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // The report waits here until the output register is free.
            if (out_free) begin
               state_in = ST_IDLE;
               if (pen_up_ff) begin
                  session_in   = 1'b0;
                  rsp_valid_in = session_ff;
                  touching_in  = 1'b0;
                  pos_x_in     = '0;
                  pos_y_in     = '0;
                  pressure_in  = '0;
               end else if (!pen_cfg_ff && (press_value == '0)) begin
                  // Without a pen signal a zero pressure always reports a release.
                  session_in   = 1'b0;
                  rsp_valid_in = 1'b1;
                  touching_in  = 1'b0;
                  pos_x_in     = '0;
                  pos_y_in     = '0;
                  pressure_in  = '0;
               end else begin
                  session_in   = 1'b1;
                  rsp_valid_in = (press_value <= PRESS_BITS'(max_ff));
                  touching_in  = 1'b1;
                  pos_x_in     = x_ff;
                  pos_y_in     = y_ff;
                  pressure_in  = press_value;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         session_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         session_ff   <= session_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      z1_ff         <= z1_in;
      pen_up_ff     <= pen_up_in;
      force_zero_ff <= force_zero_in;
      acc_ff        <= acc_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      rem_ff        <= rem_in;
      touching_ff   <= touching_in;
      pos_x_ff      <= pos_x_in;
      pos_y_ff      <= pos_y_in;
      pressure_ff   <= pressure_in;
   end

endmodule
